### rtl/pcms_pkg.sv
// ----------------------------------------------------------------------------
// pcms_pkg
// shared types and constants of the pixel configuration matrix store
// ----------------------------------------------------------------------------
package pcms_pkg;

	// default side of the square pixel matrix
	localparam int MATRIX_SIDE_DEF = 256;

	localparam int WORD_W = 32;
	localparam int BYTE_W = 8;

	// item function codes
	typedef enum logic [2:0] {
		FUNC_LOAD     = 3'd0,
		FUNC_SET_TEST = 3'd1,
		FUNC_SET_MASK = 3'd2,
		FUNC_SET_THR  = 3'd3,
		FUNC_RD_PIXEL = 3'd4,
		FUNC_RD_WORD  = 3'd5
	} func_t;

	// operation carried into the lane update
	typedef struct packed {
		func_t             func;
		logic [1:0]        lane;
		logic [BYTE_W-1:0] value;
	} op_t;

	// fields of one pixel byte
	typedef struct packed {
		logic              test_bit;
		logic              mask_bit;
		logic [3:0]        threshold_adjust;
		logic [BYTE_W-1:0] pixel_byte;
	} pix_t;

endpackage

### rtl/pcms_lane.sv
// ----------------------------------------------------------------------------
// pcms_lane
// byte lane extract and read-modify-write merge for one packed word
// ----------------------------------------------------------------------------
module pcms_lane (
	input  logic [pcms_pkg::WORD_W-1:0] word,
	input  pcms_pkg::op_t               op,
	input  logic                        fmt,
	output logic [pcms_pkg::WORD_W-1:0] new_word,
	output pcms_pkg::pix_t              pix
);
	import pcms_pkg::*;

	// bit reversal of a nibble
	localparam logic [3:0] NIBBLE_REV [16] = '{
		4'd0, 4'd8, 4'd4, 4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
		4'd1, 4'd9, 4'd5, 4'd13, 4'd3, 4'd11, 4'd7, 4'd15
	};

	logic [4:0]        sh;
	logic [BYTE_W-1:0] old_byte;
	logic [BYTE_W-1:0] upd_byte;
	logic [WORD_W-1:0] lane_mask;

	assign sh        = {op.lane, 3'b000};
	assign old_byte  = BYTE_W'(word >> sh);
	assign lane_mask = WORD_W'({BYTE_W{1'b1}}) << sh;

	always_comb begin
		case (op.func)
			FUNC_LOAD: begin
				if (fmt) begin
					upd_byte = {2'b00, op.value[5], NIBBLE_REV[op.value[4:1]], op.value[0]};
				end else begin
					upd_byte = op.value;
				end
			end
			FUNC_SET_TEST: upd_byte = {old_byte[7:6], |op.value, old_byte[4:0]};
			FUNC_SET_MASK: upd_byte = {old_byte[7:1], |op.value};
			FUNC_SET_THR:  upd_byte = {old_byte[7:5], op.value[3:0], old_byte[0]};
			default:       upd_byte = old_byte;
		endcase
	end

	assign new_word = (word & ~lane_mask) | (WORD_W'(upd_byte) << sh);

	assign pix.test_bit         = old_byte[5];
	assign pix.mask_bit         = old_byte[0];
	assign pix.threshold_adjust = old_byte[4:1];
	assign pix.pixel_byte       = old_byte;

endmodule

### rtl/pixel_config_matrix_store.sv
// ----------------------------------------------------------------------------
// pixel_config_matrix_store
// per-pixel configuration matrix held in one packed word memory
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid / in_ready  | func, x, y, value, word_index
//  out     | output    | out_valid / out_ready| packed_word, test_bit, mask_bit,
//          |           |                      | threshold_adjust, pixel_byte
//  cfg     | input     | cfg_we (no wait)     | cfg_wdata -> source_format
//
// one word per cycle sustained while the output is not stalled and no clearing
// pass runs; a read word passes the memory read register, loaded on the
// accepting edge, and then the output register
// the registered memory read sets the stage split; an item that hits the word
// of the last memory write takes it from the forwarding register
// after reset a clearing pass zeroes the store, one word a cycle, over all
// COL_WORDS*MATRIX_SIDE words (16384 at the default side); in_ready stays low
// a stalled output holds the read stage and with it in_ready; write words
// retire regardless of the output side
//
module pixel_config_matrix_store #(
	parameter int MATRIX_SIDE = pcms_pkg::MATRIX_SIDE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  logic        cfg_wdata,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [7:0]  x,
	input  logic [7:0]  y,
	input  logic [7:0]  value,
	input  logic [13:0] word_index,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] packed_word,
	output logic        test_bit,
	output logic        mask_bit,
	output logic [3:0]  threshold_adjust,
	output logic [7:0]  pixel_byte
);
	import pcms_pkg::*;

	localparam int COL_WORDS   = (MATRIX_SIDE + 3) / 4;
	localparam int STORE_WORDS = COL_WORDS * MATRIX_SIDE;
	localparam int AW          = $clog2(STORE_WORDS);

	// packed store, read data registered
	logic [WORD_W-1:0] mem [STORE_WORDS];
	logic [WORD_W-1:0] rd_data_q;

	// clearing pass
	logic          clr_active_q;
	logic [AW-1:0] clr_addr_q;

	// last write, for a read issued on the same edge as that write
	logic              fwd_valid_q;
	logic [AW-1:0]     fwd_addr_q;
	logic [WORD_W-1:0] fwd_data_q;

	logic source_format_q;

	// accept stage decode
	func_t         in_func;
	logic          x_ok;
	logic          y_ok;
	logic [7:0]    yy;
	logic [15:0]   pix_addr;
	logic [AW-1:0] addr_d;
	logic          ok_d;
	logic          accept;

	// memory stage
	logic          valid_s1;
	op_t           op_s1;
	logic          ok_s1;
	logic [AW-1:0] addr_s1;

	logic              wr_s1;
	logic              rd_pix_s1;
	logic              rd_word_s1;
	logic              s1_adv;
	logic              emit;
	logic [WORD_W-1:0] cur_word;
	logic [WORD_W-1:0] new_word;
	pix_t              pix;

	// memory write port
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [WORD_W-1:0] mem_wdata;

	// output register
	logic              out_valid_q;
	logic [WORD_W-1:0] packed_word_q;
	pix_t              pix_q;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q <= 1'b0;
		end else if (cfg_we) begin
			source_format_q <= cfg_wdata;
		end
	end

	// ---------------- address of the incoming word ----------------
	// row is flipped: yy = side-1-y, four rows share a word, lane 3 on top
	assign in_func  = func_t'(func);
	assign x_ok     = {1'b0, x} < 9'(MATRIX_SIDE);
	assign y_ok     = {1'b0, y} < 9'(MATRIX_SIDE);
	assign yy       = 8'(MATRIX_SIDE - 1) - y;
	assign pix_addr = 16'(x) * 16'(COL_WORDS) + 16'(yy[7:2]);

	always_comb begin
		if (in_func == FUNC_RD_WORD) begin
			addr_d = word_index[AW-1:0];
			ok_d   = 32'(word_index) < STORE_WORDS;
		end else begin
			addr_d = pix_addr[AW-1:0];
			ok_d   = x_ok && y_ok;
		end
	end

	assign accept   = in_valid && in_ready;
	assign in_ready = !clr_active_q && (!valid_s1 || s1_adv);

	// ---------------- memory stage ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1.func  <= in_func;
			op_s1.lane  <= ~yy[1:0];
			op_s1.value <= value;
			ok_s1       <= ok_d;
			addr_s1     <= addr_d;
		end
	end

	always_comb begin
		wr_s1      = 1'b0;
		rd_pix_s1  = 1'b0;
		rd_word_s1 = 1'b0;
		case (op_s1.func)
			FUNC_LOAD, FUNC_SET_TEST, FUNC_SET_MASK, FUNC_SET_THR: wr_s1 = 1'b1;
			FUNC_RD_PIXEL: rd_pix_s1  = 1'b1;
			FUNC_RD_WORD:  rd_word_s1 = 1'b1;
			default: ;
		endcase
	end

	// reads wait for a free output register, everything else retires
	assign s1_adv = !(rd_pix_s1 || rd_word_s1) || !out_valid_q || out_ready;
	assign emit   = valid_s1 && (rd_pix_s1 || rd_word_s1) && s1_adv;

	assign cur_word = (fwd_valid_q && fwd_addr_q == addr_s1) ? fwd_data_q : rd_data_q;

	pcms_lane u_lane (
		.word     (cur_word),
		.op       (op_s1),
		.fmt      (source_format_q),
		.new_word (new_word),
		.pix      (pix)
	);

	// ---------------- store ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(STORE_WORDS - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	assign mem_we    = clr_active_q || (valid_s1 && wr_s1 && ok_s1);
	assign mem_waddr = clr_active_q ? clr_addr_q : addr_s1;
	assign mem_wdata = clr_active_q ? '0 : new_word;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			rd_data_q <= mem[addr_d];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (mem_we) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			fwd_addr_q <= mem_waddr;
			fwd_data_q <= mem_wdata;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// out-of-range reads and the fields that do not belong to the read give zero
	always_ff @(posedge clk) begin
		if (emit) begin
			packed_word_q <= (rd_word_s1 && ok_s1) ? cur_word : '0;
			pix_q         <= (rd_pix_s1 && ok_s1) ? pix : '0;
		end
	end

	assign out_valid        = out_valid_q;
	assign packed_word      = packed_word_q;
	assign test_bit         = pix_q.test_bit;
	assign mask_bit         = pix_q.mask_bit;
	assign threshold_adjust = pix_q.threshold_adjust;
	assign pixel_byte       = pix_q.pixel_byte;

`ifndef SYNTHESIS
	// no item enters while the store is being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !in_ready)
		else $error("item accepted during clearing pass");

	// an item write never collides with the clearing pass
	a_no_item_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && wr_s1 && ok_s1) |-> !clr_active_q)
		else $error("item write during clearing pass");

	// clearing ends only after the last word
	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_active_q) |-> $past(clr_addr_q) == AW'(STORE_WORDS - 1))
		else $error("clearing pass ended early");

	// a result is either a word read or a pixel read, never both
	a_result_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (packed_word_q == '0 || pix_q == '0))
		else $error("word and pixel fields both set");

	// a pending result is not overwritten while the read stage waits
	a_read_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (rd_pix_s1 || rd_word_s1) && out_valid_q && !out_ready)
		|=> valid_s1 && $stable(op_s1) && $stable(addr_s1))
		else $error("read stage lost its word while stalled");
`endif

endmodule
